/* src/second_chance_frame_table_core_defines.svh */
// assertion macros for the second chance frame table core
`ifndef SECOND_CHANCE_FRAME_TABLE_CORE_DEFINES_SVH
`define SECOND_CHANCE_FRAME_TABLE_CORE_DEFINES_SVH

// condition holds in the same cycle
`define SCFT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame table check failed");

// condition holds in the following cycle
`define SCFT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame table check failed");

`endif

/* src/scft_pkg.sv */
package scft_pkg;

    // request kinds
    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_UPDATE = 2'd2,
        REQ_VICTIM = 2'd3
    } t_req;

    // back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EVAL,
        BK_PICK,
        BK_APPLY
    } t_bk_state;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_NOVICTIM = 2'd3;

    // eviction actions
    localparam logic [1:0] ACT_NONE      = 2'd0;
    localparam logic [1:0] ACT_CLEAN     = 2'd1;
    localparam logic [1:0] ACT_WRITEBACK = 2'd2;
    localparam logic [1:0] ACT_SWAP      = 2'd3;

    // flag bit positions
    localparam int FLAG_BITS = 5;
    localparam int FL_FILE   = 0;
    localparam int FL_WRITE  = 1;
    localparam int FL_ACC    = 2;
    localparam int FL_DIRTY  = 3;
    localparam int FL_PIN    = 4;

endpackage

/* src/second_chance_frame_table_core.sv */
// Second-chance frame table. Requests (add, remove, update bits, choose victim)
// are taken when start is high and busy is low; each one gives exactly one
// result, shown for one cycle with o_done high, which must be captured then.
// A two-deep request queue sits in front of the execution sequencer, so two
// requests can be taken while one is being worked on; busy rises when it fills.
// The sequencer takes each request through fetch, a compare of all entries,
// a pick of the oldest match (or of the first free cell for an add), and an
// apply step that registers the result; it fetches the next request from the
// queue only after the last one is applied. The whole victim search, both
// passes of the second-chance scan, resolves in that single compare and pick.
// Entries are kept oldest first in a shifting row of cells; reset empties the table at once.
`include "second_chance_frame_table_core_defines.svh"

module second_chance_frame_table_core #(
    parameter int FRAMES     = 64,
    parameter int FRAME_BITS = 20,
    parameter int PAGE_BITS  = 20,
    parameter int OWNER_BITS = 8,
    localparam int CW = $clog2(FRAMES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_req_type,
    input  logic [FRAME_BITS-1:0] i_frame_num,
    input  logic [PAGE_BITS-1:0]  i_page_num,
    input  logic [OWNER_BITS-1:0] i_owner_id,
    input  logic                  i_from_file,
    input  logic                  i_is_writable,
    input  logic                  i_set_accessed,
    input  logic                  i_set_dirty,
    input  logic                  i_pin,
    output logic                  o_done,
    output logic [1:0]            o_status,
    output logic [FRAME_BITS-1:0] o_victim_frame,
    output logic [PAGE_BITS-1:0]  o_victim_page,
    output logic [OWNER_BITS-1:0] o_victim_owner,
    output logic [1:0]            o_evict_action,
    output logic [CW-1:0]         o_entry_count
);

    localparam int W = 2 + FRAME_BITS + PAGE_BITS + OWNER_BITS + 5;

    logic         q_full, q_push, q_pop, q_valid;
    logic [W-1:0] q_in, q_out;
    logic         done_err;

    // request intake
    scft_front #(
        .FRAME_BITS(FRAME_BITS),
        .PAGE_BITS (PAGE_BITS),
        .OWNER_BITS(OWNER_BITS)
    ) u_front (
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_frame_num   (i_frame_num),
        .i_page_num    (i_page_num),
        .i_owner_id    (i_owner_id),
        .i_from_file   (i_from_file),
        .i_is_writable (i_is_writable),
        .i_set_accessed(i_set_accessed),
        .i_set_dirty   (i_set_dirty),
        .i_pin         (i_pin),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_in)
    );

    // request queue
    scft_fifo #(
        .WIDTH(W)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_data (q_out)
    );

    // table and execution
    scft_back #(
        .FRAMES    (FRAMES),
        .FRAME_BITS(FRAME_BITS),
        .PAGE_BITS (PAGE_BITS),
        .OWNER_BITS(OWNER_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (q_out),
        .o_q_pop       (q_pop),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_victim_frame(o_victim_frame),
        .o_victim_page (o_victim_page),
        .o_victim_owner(o_victim_owner),
        .o_evict_action(o_evict_action),
        .o_entry_count (o_entry_count)
    );

    // result carrying an error status
    assign done_err = o_done && (o_status != scft_pkg::ST_OK);

    // results never come in adjacent cycles
    `SCFT_ASSERT_NEXT(a_done_spaced, o_done, !o_done)
    // count never exceeds the table size when a result is shown
    `SCFT_ASSERT_NOW(a_count_range, o_done, o_entry_count <= CW'(FRAMES))
    // no eviction action on an error result, which has no victim
    `SCFT_ASSERT_NOW(a_no_action, done_err, o_evict_action == scft_pkg::ACT_NONE)

endmodule

/* src/scft_fifo.sv */
module scft_fifo #(
    parameter int WIDTH = 56
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_data [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_data[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

/* src/scft_front.sv */
module scft_front #(
    parameter int FRAME_BITS = 20,
    parameter int PAGE_BITS  = 20,
    parameter int OWNER_BITS = 8,
    localparam int W = 2 + FRAME_BITS + PAGE_BITS + OWNER_BITS + 5
) (
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_req_type,
    input  logic [FRAME_BITS-1:0] i_frame_num,
    input  logic [PAGE_BITS-1:0]  i_page_num,
    input  logic [OWNER_BITS-1:0] i_owner_id,
    input  logic                  i_from_file,
    input  logic                  i_is_writable,
    input  logic                  i_set_accessed,
    input  logic                  i_set_dirty,
    input  logic                  i_pin,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output logic [W-1:0]          o_q_data
);

    scft_pkg::t_req req;

    // decode the request kind
    assign req = scft_pkg::t_req'(i_req_type);

    // accept while the queue has room
    assign busy     = i_q_full;
    assign o_q_push = start && !i_q_full;

    // pack the request, flag bits other than pin only where the kind uses them
    assign o_q_data = {req, i_frame_num, i_page_num, i_owner_id,
                       i_from_file   && (req == scft_pkg::REQ_ADD),
                       i_is_writable && (req == scft_pkg::REQ_ADD),
                       i_set_accessed && (req == scft_pkg::REQ_UPDATE),
                       i_set_dirty    && (req == scft_pkg::REQ_UPDATE),
                       i_pin};

endmodule

/* src/scft_back.sv */
module scft_back #(
    parameter int FRAMES     = 64,
    parameter int FRAME_BITS = 20,
    parameter int PAGE_BITS  = 20,
    parameter int OWNER_BITS = 8,
    localparam int W  = 2 + FRAME_BITS + PAGE_BITS + OWNER_BITS + 5,
    localparam int CW = $clog2(FRAMES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  logic [W-1:0]          i_q_data,
    output logic                  o_q_pop,
    output logic                  o_done,
    output logic [1:0]            o_status,
    output logic [FRAME_BITS-1:0] o_victim_frame,
    output logic [PAGE_BITS-1:0]  o_victim_page,
    output logic [OWNER_BITS-1:0] o_victim_owner,
    output logic [1:0]            o_evict_action,
    output logic [CW-1:0]         o_entry_count
);

    localparam int FB = scft_pkg::FLAG_BITS;

    scft_pkg::t_bk_state r_state, n_state;

    // latched request
    logic [W-1:0]          r_cmd;
    logic [1:0]            cmd_type;
    scft_pkg::t_req        cmd_req;
    logic [FRAME_BITS-1:0] cmd_frame;
    logic [PAGE_BITS-1:0]  cmd_page;
    logic [OWNER_BITS-1:0] cmd_owner;
    logic                  cmd_file, cmd_write, cmd_acc, cmd_dirty, cmd_pin;

    // entry cells
    logic [FRAME_BITS-1:0] r_frame [FRAMES];
    logic [PAGE_BITS-1:0]  r_page  [FRAMES];
    logic [OWNER_BITS-1:0] r_owner [FRAMES];
    logic [FB-1:0]         r_flags [FRAMES];
    logic [FB-1:0]         cf      [FRAMES];
    logic [CW-1:0]         r_cnt;

    // per-cell compare results and selection
    logic [FRAMES-1:0] r_match, r_c1, r_c2, r_sel;
    logic [FRAMES-1:0] n_match, n_c1, n_c2, n_sel, dec_add, lt, ge;
    logic              r_found, r_all, n_found, n_all;

    // gathered victim fields
    logic [FRAME_BITS-1:0] vf;
    logic [PAGE_BITS-1:0]  vp;
    logic [OWNER_BITS-1:0] vo;
    logic [FB-1:0]         vfl;
    logic                  shift_en, is_victim;

    assign {cmd_type, cmd_frame, cmd_page, cmd_owner,
            cmd_file, cmd_write, cmd_acc, cmd_dirty, cmd_pin} = r_cmd;
    assign cmd_req = scft_pkg::t_req'(cmd_type);

    // next state
    always_comb begin
        case (r_state)
            scft_pkg::BK_IDLE:  n_state = i_q_valid ? scft_pkg::BK_EVAL : scft_pkg::BK_IDLE;
            scft_pkg::BK_EVAL:  n_state = scft_pkg::BK_PICK;
            scft_pkg::BK_PICK:  n_state = scft_pkg::BK_APPLY;
            scft_pkg::BK_APPLY: n_state = scft_pkg::BK_IDLE;
            default:            n_state = scft_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop = 1'b0;
        case (r_state)
            scft_pkg::BK_IDLE: o_q_pop = i_q_valid;
            default:           o_q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scft_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_data;
        end
    end

    // compare every live cell against the request
    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            logic live;
            logic cand;
            live = (CW'(i) < r_cnt);
            cand = live && !r_flags[i][scft_pkg::FL_PIN] &&
                   (r_flags[i][scft_pkg::FL_FILE] || r_flags[i][scft_pkg::FL_WRITE]);
            n_match[i] = live && (r_frame[i] == cmd_frame);
            n_c1[i]    = cand && !r_flags[i][scft_pkg::FL_ACC];
            n_c2[i]    = cand;
            dec_add[i] = (CW'(i) == r_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == scft_pkg::BK_EVAL) begin
            r_match <= n_match;
            r_c1    <= n_c1;
            r_c2    <= n_c2;
        end
    end

    // pick the oldest qualifying cell as a one-hot vector, or the first free cell for an add
    always_comb begin
        n_all = 1'b0;
        case (cmd_req)
            scft_pkg::REQ_ADD: begin
                n_sel   = dec_add;
                n_found = (r_cnt < CW'(FRAMES));
            end
            scft_pkg::REQ_REMOVE, scft_pkg::REQ_UPDATE: begin
                n_sel   = r_match & (~r_match + FRAMES'(1));
                n_found = |r_match;
            end
            default: begin
                if (|r_c1) begin
                    n_sel = r_c1 & (~r_c1 + FRAMES'(1));
                end else begin
                    n_sel = r_c2 & (~r_c2 + FRAMES'(1));
                    n_all = 1'b1;
                end
                n_found = |r_c2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == scft_pkg::BK_PICK) begin
            r_sel   <= n_sel;
            r_found <= n_found;
            r_all   <= n_all;
        end
    end

    // masks below and from the chosen cell, cleared accessed bits
    assign lt        = r_sel - FRAMES'(1);
    assign ge        = ~lt;
    assign is_victim = (cmd_req == scft_pkg::REQ_VICTIM);
    assign shift_en  = r_found && (cmd_req == scft_pkg::REQ_REMOVE || is_victim);

    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            cf[i] = r_flags[i];
            if (is_victim && !r_flags[i][scft_pkg::FL_PIN] && (r_all || lt[i])) begin
                cf[i][scft_pkg::FL_ACC] = 1'b0;
            end
        end
    end

    // gather the chosen cell
    always_comb begin
        vf  = '0;
        vp  = '0;
        vo  = '0;
        vfl = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (r_sel[i]) begin
                vf  = vf | r_frame[i];
                vp  = vp | r_page[i];
                vo  = vo | r_owner[i];
                vfl = vfl | r_flags[i];
            end
        end
    end

    // cell updates: shift down on removal or victim, write on add, flags on update, accessed bits cleared on victim
    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (r_state == scft_pkg::BK_APPLY) begin
                if (cmd_req == scft_pkg::REQ_ADD && r_found && r_sel[g]) begin
                    r_frame[g] <= cmd_frame;
                    r_page[g]  <= cmd_page;
                    r_owner[g] <= cmd_owner;
                    r_flags[g] <= {cmd_pin, 1'b0, 1'b0, cmd_write, cmd_file};
                end else if (cmd_req == scft_pkg::REQ_UPDATE && r_found && r_sel[g]) begin
                    r_flags[g] <= {cmd_pin,
                                   r_flags[g][scft_pkg::FL_DIRTY] | cmd_dirty,
                                   r_flags[g][scft_pkg::FL_ACC] | cmd_acc,
                                   r_flags[g][scft_pkg::FL_WRITE],
                                   r_flags[g][scft_pkg::FL_FILE]};
                end else if (shift_en && ge[g]) begin
                    if (g < FRAMES - 1) begin
                        r_frame[g] <= r_frame[(g + 1) % FRAMES];
                        r_page[g]  <= r_page[(g + 1) % FRAMES];
                        r_owner[g] <= r_owner[(g + 1) % FRAMES];
                        r_flags[g] <= cf[(g + 1) % FRAMES];
                    end
                end else if (is_victim) begin
                    r_flags[g] <= cf[g];
                end
            end
        end
    end

    // fill count and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= (r_state == scft_pkg::BK_APPLY);
            if (r_state == scft_pkg::BK_APPLY) begin
                if (cmd_req == scft_pkg::REQ_ADD && r_found) begin
                    r_cnt <= r_cnt + CW'(1);
                end else if (shift_en) begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == scft_pkg::BK_APPLY) begin
            o_victim_frame <= '0;
            o_victim_page  <= '0;
            o_victim_owner <= '0;
            o_evict_action <= scft_pkg::ACT_NONE;
            o_status       <= scft_pkg::ST_OK;
            o_entry_count  <= r_cnt;
            case (cmd_req)
                scft_pkg::REQ_ADD: begin
                    if (r_found) begin
                        o_entry_count <= r_cnt + CW'(1);
                    end else begin
                        o_status <= scft_pkg::ST_FULL;
                    end
                end
                scft_pkg::REQ_REMOVE: begin
                    if (r_found) begin
                        o_entry_count <= r_cnt - CW'(1);
                    end else begin
                        o_status <= scft_pkg::ST_NOTFOUND;
                    end
                end
                scft_pkg::REQ_UPDATE: begin
                    if (!r_found) begin
                        o_status <= scft_pkg::ST_NOTFOUND;
                    end
                end
                default: begin
                    if (r_found) begin
                        o_entry_count  <= r_cnt - CW'(1);
                        o_victim_frame <= vf;
                        o_victim_page  <= vp;
                        o_victim_owner <= vo;
                        if (vfl[scft_pkg::FL_FILE]) begin
                            o_evict_action <= vfl[scft_pkg::FL_DIRTY] ?
                                              scft_pkg::ACT_WRITEBACK : scft_pkg::ACT_CLEAN;
                        end else begin
                            o_evict_action <= scft_pkg::ACT_SWAP;
                        end
                    end else begin
                        o_status <= scft_pkg::ST_NOVICTIM;
                    end
                end
            endcase
        end
    end

endmodule

/* bench/tb_second_chance_frame_table_core.sv */
module tb_second_chance_frame_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;

    // one reply from the frame table
    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] vframe;
        logic [19:0] vpage;
        logic [7:0]  vowner;
        logic [1:0]  action;
        logic [6:0]  count;
    } t_reply;

    int unsigned mismatch_count = 0;

    // print one line per mismatch and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("error: %s got %0h want %0h", what, got, want);
    endtask

    // frame table shadow and queue of pending replies
    class frame_table_scoreboard;
        logic [19:0] frame_q[$];
        logic [19:0] page_q[$];
        logic [7:0]  owner_q[$];
        logic [4:0]  flags_q[$];
        t_reply      pending[$];

        function int find_frame(logic [19:0] f);
            foreach (frame_q[i]) begin
                if (frame_q[i] == f) return i;
            end
            return -1;
        endfunction

        function void drop(int idx);
            frame_q.delete(idx);
            page_q.delete(idx);
            owner_q.delete(idx);
            flags_q.delete(idx);
        endfunction

        // apply one accepted request and queue its reply
        function void note_request(scft_pkg::t_req req, logic [19:0] f, logic [19:0] p,
                                   logic [7:0] o, logic ff, logic fw, logic sa,
                                   logic sd, logic pn);
            t_reply r;
            int idx;
            int n;
            int chosen;
            logic [4:0] fl;
            r = '0;
            r.status = scft_pkg::ST_OK;
            r.action = scft_pkg::ACT_NONE;
            case (req)
                scft_pkg::REQ_ADD: begin
                    if (frame_q.size() >= DEPTH) begin
                        r.status = scft_pkg::ST_FULL;
                    end else begin
                        fl = '0;
                        fl[scft_pkg::FL_FILE] = ff;
                        fl[scft_pkg::FL_WRITE] = fw;
                        fl[scft_pkg::FL_PIN] = pn;
                        frame_q.push_back(f);
                        page_q.push_back(p);
                        owner_q.push_back(o);
                        flags_q.push_back(fl);
                    end
                end
                scft_pkg::REQ_REMOVE: begin
                    idx = find_frame(f);
                    if (idx < 0) r.status = scft_pkg::ST_NOTFOUND;
                    else drop(idx);
                end
                scft_pkg::REQ_UPDATE: begin
                    idx = find_frame(f);
                    if (idx < 0) begin
                        r.status = scft_pkg::ST_NOTFOUND;
                    end else begin
                        if (sa) flags_q[idx][scft_pkg::FL_ACC] = 1'b1;
                        if (sd) flags_q[idx][scft_pkg::FL_DIRTY] = 1'b1;
                        flags_q[idx][scft_pkg::FL_PIN] = pn;
                    end
                end
                default: begin
                    // second-chance scan, two passes at most
                    n = frame_q.size();
                    chosen = -1;
                    for (int s = 0; s < 2 * n; s++) begin
                        idx = s % n;
                        fl = flags_q[idx];
                        if (fl[scft_pkg::FL_PIN]) continue;
                        if (fl[scft_pkg::FL_ACC]) begin
                            flags_q[idx][scft_pkg::FL_ACC] = 1'b0;
                            continue;
                        end
                        if (fl[scft_pkg::FL_FILE] || fl[scft_pkg::FL_WRITE]) begin
                            chosen = idx;
                            break;
                        end
                    end
                    if (chosen < 0) begin
                        r.status = scft_pkg::ST_NOVICTIM;
                    end else begin
                        fl = flags_q[chosen];
                        r.vframe = frame_q[chosen];
                        r.vpage = page_q[chosen];
                        r.vowner = owner_q[chosen];
                        if (fl[scft_pkg::FL_FILE])
                            r.action = fl[scft_pkg::FL_DIRTY] ? scft_pkg::ACT_WRITEBACK
                                                              : scft_pkg::ACT_CLEAN;
                        else r.action = scft_pkg::ACT_SWAP;
                        drop(chosen);
                    end
                end
            endcase
            r.count = 7'(frame_q.size());
            pending.push_back(r);
        endfunction

        // compare one reply with the oldest expectation
        task check_reply(t_reply got);
            t_reply want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected reply", 32'(got.status), 32'd0);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.vframe !== want.vframe)
                report_mismatch("victim_frame", 32'(got.vframe), 32'(want.vframe));
            if (got.vpage !== want.vpage)
                report_mismatch("victim_page", 32'(got.vpage), 32'(want.vpage));
            if (got.vowner !== want.vowner)
                report_mismatch("victim_owner", 32'(got.vowner), 32'(want.vowner));
            if (got.action !== want.action)
                report_mismatch("evict_action", 32'(got.action), 32'(want.action));
            if (got.count !== want.count)
                report_mismatch("entry_count", 32'(got.count), 32'(want.count));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_req_type = '0;
    logic [19:0] i_frame_num = '0;
    logic [19:0] i_page_num = '0;
    logic [7:0]  i_owner_id = '0;
    logic        i_from_file = 1'b0;
    logic        i_is_writable = 1'b0;
    logic        i_set_accessed = 1'b0;
    logic        i_set_dirty = 1'b0;
    logic        i_pin = 1'b0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [19:0] o_victim_frame;
    logic [19:0] o_victim_page;
    logic [7:0]  o_victim_owner;
    logic [1:0]  o_evict_action;
    logic [6:0]  o_entry_count;

    frame_table_scoreboard table_sb = new();
    int unsigned idle_pct = 0;
    logic [19:0] recent_frames[$];

    always #5 i_clk = ~i_clk;

    second_chance_frame_table_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_frame_num(i_frame_num), .i_page_num(i_page_num),
        .i_owner_id(i_owner_id), .i_from_file(i_from_file),
        .i_is_writable(i_is_writable), .i_set_accessed(i_set_accessed),
        .i_set_dirty(i_set_dirty), .i_pin(i_pin), .o_done(o_done),
        .o_status(o_status), .o_victim_frame(o_victim_frame),
        .o_victim_page(o_victim_page), .o_victim_owner(o_victim_owner),
        .o_evict_action(o_evict_action), .o_entry_count(o_entry_count)
    );

    // reply monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            table_sb.check_reply({o_status, o_victim_frame, o_victim_page,
                                  o_victim_owner, o_evict_action, o_entry_count});
        end
    end

    // issue one request and hold it until accepted
    task automatic send_request(input scft_pkg::t_req req, input logic [19:0] f,
                                input logic [19:0] p, input logic [7:0] o,
                                input logic [4:0] bits);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= req;
        i_frame_num <= f;
        i_page_num <= p;
        i_owner_id <= o;
        {i_from_file, i_is_writable, i_set_accessed, i_set_dirty, i_pin} <= bits;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        table_sb.note_request(req, f, p, o, bits[4], bits[3], bits[2], bits[1], bits[0]);
        if (req == scft_pkg::REQ_ADD) recent_frames.push_back(f);
        if (recent_frames.size() > 80) void'(recent_frames.pop_front());
    endtask

    // random request, mostly reusing recently added frame numbers
    task automatic send_random;
        scft_pkg::t_req req;
        logic [19:0] f;
        int unsigned sel;
        sel = $urandom_range(99);
        if (table_sb.frame_q.size() < 8)
            req = (sel < 70) ? scft_pkg::REQ_ADD : scft_pkg::t_req'($urandom_range(3));
        else if (table_sb.frame_q.size() > 56)
            req = (sel < 15) ? scft_pkg::REQ_ADD : scft_pkg::t_req'($urandom_range(3));
        else req = scft_pkg::t_req'($urandom_range(3));
        if (recent_frames.size() > 0 && $urandom_range(99) < 80)
            f = recent_frames[$urandom_range(recent_frames.size() - 1)];
        else if ($urandom_range(1)) f = 20'($urandom_range(63));
        else f = 20'($urandom);
        send_request(req, f, 20'($urandom), 8'($urandom), 5'($urandom));
    endtask

    // stop sending and wait for every expected reply
    task automatic wait_drained;
        start <= 1'b0;
        @(posedge i_clk);
        while (table_sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        int unsigned seg;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes, several flag mixes
        send_request(scft_pkg::REQ_VICTIM, '0, '0, '0, '0);
        send_request(scft_pkg::REQ_REMOVE, 20'hfffff, '0, '0, '0);
        send_request(scft_pkg::REQ_UPDATE, 20'h0, '0, '0, 5'b11111);
        send_request(scft_pkg::REQ_ADD, 20'hfffff, 20'hfffff, 8'hff, 5'b00000);
        send_request(scft_pkg::REQ_VICTIM, '0, '0, '0, '0);
        send_request(scft_pkg::REQ_ADD, 20'h0, 20'h0, 8'h0, 5'b10001);
        send_request(scft_pkg::REQ_VICTIM, '0, '0, '0, '0);
        send_request(scft_pkg::REQ_ADD, 20'h1, 20'h12345, 8'h5a, 5'b10000);
        send_request(scft_pkg::REQ_ADD, 20'h2, 20'habcde, 8'ha5, 5'b01000);
        send_request(scft_pkg::REQ_ADD, 20'h3, 20'h55555, 8'h33, 5'b11000);
        send_request(scft_pkg::REQ_ADD, 20'h1, 20'h77777, 8'h11, 5'b01000);
        send_request(scft_pkg::REQ_UPDATE, 20'h1, '0, '0, 5'b00110);
        send_request(scft_pkg::REQ_UPDATE, 20'h3, '0, '0, 5'b00010);
        send_request(scft_pkg::REQ_UPDATE, 20'h0, '0, '0, 5'b00000);
        send_request(scft_pkg::REQ_VICTIM, '0, '0, '0, '0);
        send_request(scft_pkg::REQ_VICTIM, '0, '0, '0, '0);
        send_request(scft_pkg::REQ_VICTIM, '0, '0, '0, '0);
        send_request(scft_pkg::REQ_REMOVE, 20'h1, '0, '0, '0);
        send_request(scft_pkg::REQ_REMOVE, 20'hfffff, '0, '0, '0);
        send_request(scft_pkg::REQ_VICTIM, '0, '0, '0, '0);
        send_request(scft_pkg::REQ_VICTIM, '0, '0, '0, '0);
        wait_drained();

        // fill the table past full, then take four victims from it
        for (int k = 0; k < DEPTH + 2; k++)
            send_request(scft_pkg::REQ_ADD, 20'(k), 20'($urandom), 8'($urandom),
                         {1'($urandom_range(1)), 1'b1, 3'b000});
        for (int k = 0; k < 4; k++) send_request(scft_pkg::REQ_VICTIM, '0, '0, '0, '0);

        // random phases with different sender idling
        for (seg = 0; seg < 3; seg++) begin
            idle_pct = (seg == 0) ? 26 : (seg == 1) ? 67 : 0;
            for (int k = 0; k < 530; k++) begin
                send_random();
                if (k == 200) wait_drained();
            end
        end
        idle_pct = 0;

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("second_chance_frame_table_core: match");
        end else begin
            $display("second_chance_frame_table_core: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2ms;
        $display("second_chance_frame_table_core: mismatch");
        $finish;
    end

endmodule

/* second_chance_frame_table_core.f */
+incdir+src
src/scft_pkg.sv
src/scft_fifo.sv
src/scft_front.sv
src/scft_back.sv
src/second_chance_frame_table_core.sv
bench/tb_second_chance_frame_table_core.sv
